// ===== hdl/plic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_pkg: shared types and constants of the point-to-line inlier counter
// Item, result and line configuration structs, register indexes and the
// queue depths between the front and back parts.
// ----------------------------------------------------------------------------
package plic_pkg;

	// register indexes on the configuration channel
	localparam int          REG_IDX_W          = 3;
	localparam logic [2:0]  REG_LINE_POINT_X   = 3'd0;
	localparam logic [2:0]  REG_LINE_POINT_Y   = 3'd1;
	localparam logic [2:0]  REG_LINE_POINT_Z   = 3'd2;
	localparam logic [2:0]  REG_LINE_DIR_X     = 3'd3;
	localparam logic [2:0]  REG_LINE_DIR_Y     = 3'd4;
	localparam logic [2:0]  REG_LINE_DIR_Z     = 3'd5;
	localparam logic [2:0]  REG_THRESHOLD_SQR  = 3'd6;

	localparam int          CFG_DATA_W         = 58;
	localparam logic [15:0] DIR_X_RESET        = 16'sd16384;

	// distance and count limits
	localparam logic [57:0] DIST_MAX           = {58{1'b1}};
	localparam int          CNT_FIELD_MAX      = 2097151;

	// queue depths
	localparam int          MID_DEPTH          = 4;
	localparam int          OUT_DEPTH          = 8;
	localparam int          OUT_LVL_W          = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic        [19:0] point_index;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic               is_inlier;
		logic        [19:0] inlier_index;
		logic        [57:0] dist_sq;
		logic        [20:0] inlier_total;
		logic               last_result;
	} result_t;

	// offset of the line point from the point (line point - point), as held in the middle queue
	typedef struct packed {
		logic signed [24:0] ax;
		logic signed [24:0] ay;
		logic signed [24:0] az;
		logic        [19:0] point_index;
		logic               last_point;
	} diff_t;

	typedef struct packed {
		logic signed [23:0] line_point_x;
		logic signed [23:0] line_point_y;
		logic signed [23:0] line_point_z;
		logic signed [15:0] line_dir_x;
		logic signed [15:0] line_dir_y;
		logic signed [15:0] line_dir_z;
		logic        [57:0] threshold_squared;
	} cfg_t;

	// line through the origin along x, threshold zero
	localparam cfg_t CFG_RESET = {24'd0, 24'd0, 24'd0, DIR_X_RESET, 16'd0, 16'd0, 58'd0};

endpackage

// ===== hdl/point_line_inlier_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_line_inlier_counter_core: 3D point-to-line inlier test and counter
//
// Points enter through a queue-like port: an item is taken at a clock edge
// with push high and full low. Results leave the same way: while empty is
// low the oldest result sits on the result port, and it is taken at an edge
// with pop high. Each point gives exactly one result, in order.
// The line (point, unit direction) and the squared threshold are written on
// the cfg channel (cfg_ready is always high); the user must do so only while
// no item is in flight; the block itself does not enforce this.
// Throughput: one point per cycle while the result queue has room, set by
// the four-entry middle queue and the three-stage distance pipeline (one
// multiplier stage, one magnitude stage, one squaring stage). The back part
// draws from the middle queue only while the eight-entry result queue has
// room for all items in flight, so a stalled receiver fills the result
// queue, then the middle queue, then full rises; nothing is dropped.
// Reset clears both queues, the pipeline and the inlier count, and sets the
// line to the origin along x with a threshold of zero.
// ----------------------------------------------------------------------------
module point_line_inlier_counter_core
	import plic_pkg::*;
#(
	parameter int MAX_POINTS    = 1048576,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  point_t                point,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                       cfg_q;
	logic                       take;
	logic                       item_valid;
	diff_t                      item;
	logic                       res_valid;
	result_t                    res;
	logic [OUT_LVL_W-1:0]       out_level;
	logic [$bits(result_t)-1:0] out_bits;
	logic                       out_full;

	assign cfg_ready = 1'b1;

	// write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINE_POINT_X:  cfg_q.line_point_x      <= cfg_data[23:0];
				REG_LINE_POINT_Y:  cfg_q.line_point_y      <= cfg_data[23:0];
				REG_LINE_POINT_Z:  cfg_q.line_point_z      <= cfg_data[23:0];
				REG_LINE_DIR_X:    cfg_q.line_dir_x        <= cfg_data[15:0];
				REG_LINE_DIR_Y:    cfg_q.line_dir_y        <= cfg_data[15:0];
				REG_LINE_DIR_Z:    cfg_q.line_dir_z        <= cfg_data[15:0];
				REG_THRESHOLD_SQR: cfg_q.threshold_squared <= cfg_data[57:0];
				default: begin
				end
			endcase
		end
	end

	plic_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.point      (point),
		.cfg        (cfg_q),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	plic_back #(
		.MAX_POINTS    (MAX_POINTS),
		.DIR_FRAC_BITS (DIR_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_item   (item),
		.take      (take),
		.cfg       (cfg_q),
		.out_level (out_level),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue; the back part never writes it when full
	plic_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (out_bits),
		.full    (out_full),
		.empty   (empty),
		.level   (out_level)
	);

	// out_full is covered by the credit check in the back part
	assign result = out_full ? out_bits : out_bits;

endmodule

// ===== hdl/plic_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_fifo: small first-in first-out queue
// Register slots with a head read, a fill level and full / empty flags.
// ----------------------------------------------------------------------------
module plic_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [WIDTH-1:0]               wr_data,
	input  logic                           rd_en,
	output logic [WIDTH-1:0]               rd_data,
	output logic                           full,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// store the incoming item
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + LW'(1);
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

// ===== hdl/plic_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_front: input side of the inlier counter
// Accepts points, forms the offset from the line point and parks it in the
// middle queue for the back part.
// ----------------------------------------------------------------------------
module plic_front
	import plic_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  point_t point,
	input  cfg_t   cfg,
	input  logic   take,
	output logic   item_valid,
	output diff_t  item
);

	diff_t                      offset;
	logic [$bits(diff_t)-1:0]   rd_bits;
	logic                       mid_empty;

	// offset = line point - point, one bit wider than the coordinates
	always_comb begin
		offset.ax          = {cfg.line_point_x[23], cfg.line_point_x}
		                     - {point.point_x[23], point.point_x};
		offset.ay          = {cfg.line_point_y[23], cfg.line_point_y}
		                     - {point.point_y[23], point.point_y};
		offset.az          = {cfg.line_point_z[23], cfg.line_point_z}
		                     - {point.point_z[23], point.point_z};
		offset.point_index = point.point_index;
		offset.last_point  = point.last_point;
	end

	plic_fifo #(
		.WIDTH ($bits(diff_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (offset),
		.rd_en   (take),
		.rd_data (rd_bits),
		.full    (full),
		.empty   (mid_empty),
		.level   ()
	);

	assign item       = rd_bits;
	assign item_valid = !mid_empty;

endmodule

// ===== hdl/plic_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_back: distance pipeline of the inlier counter
// Cross product, magnitude and squares over three stages, then the sum, the
// threshold compare and the running inlier count. Items are drawn from the
// middle queue only when the result queue has room for everything in flight.
// ----------------------------------------------------------------------------
module plic_back
	import plic_pkg::*;
#(
	parameter int MAX_POINTS    = 1048576,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  diff_t                in_item,
	output logic                 take,
	input  cfg_t                 cfg,
	input  logic [OUT_LVL_W-1:0] out_level,
	output logic                 res_valid,
	output result_t              res
);

	localparam int          CAP_INT   = (MAX_POINTS > CNT_FIELD_MAX) ? CNT_FIELD_MAX
	                                                                 : MAX_POINTS;
	localparam logic [20:0] COUNT_CAP = 21'(CAP_INT);

	// stage 1: six products of the cross product
	logic               v_s1;
	logic signed [40:0] prod_s1 [6];
	logic        [19:0] idx_s1;
	logic               last_s1;

	// stage 2: component magnitudes
	logic               v_s2;
	logic        [28:0] mag_s2 [3];
	logic               sat_s2;
	logic        [19:0] idx_s2;
	logic               last_s2;

	// stage 3: squares
	logic               v_s3;
	logic        [57:0] sq_s3 [3];
	logic               sat_s3;
	logic        [19:0] idx_s3;
	logic               last_s3;

	logic        [20:0] count_q;

	logic [OUT_LVL_W:0] used;
	logic signed [41:0] diff   [3];
	logic signed [41:0] shr    [3];
	logic        [41:0] absval [3];
	logic               big;
	logic        [59:0] sum;
	logic        [57:0] dist_sat;
	logic               inl;
	logic        [20:0] total;

	// issue only while the result queue can take every item in flight
	always_comb begin
		used = {1'b0, out_level} + (OUT_LVL_W+1)'(v_s1) + (OUT_LVL_W+1)'(v_s2)
		       + (OUT_LVL_W+1)'(v_s3);
		take = in_valid && (used < (OUT_LVL_W+1)'(OUT_DEPTH));
	end

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: multiply offset by direction
	always_ff @(posedge clk) begin
		prod_s1[0] <= in_item.ay * cfg.line_dir_z;
		prod_s1[1] <= in_item.az * cfg.line_dir_y;
		prod_s1[2] <= in_item.az * cfg.line_dir_x;
		prod_s1[3] <= in_item.ax * cfg.line_dir_z;
		prod_s1[4] <= in_item.ax * cfg.line_dir_y;
		prod_s1[5] <= in_item.ay * cfg.line_dir_x;
		idx_s1     <= in_item.point_index;
		last_s1    <= in_item.last_point;
	end

	// stage 2 logic: subtract, shift down to Q.0, take magnitude
	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff[i]   = 42'(prod_s1[2*i]) - 42'(prod_s1[2*i+1]);
			shr[i]    = diff[i] >>> DIR_FRAC_BITS;
			absval[i] = shr[i][41] ? (~shr[i] + 42'd1) : shr[i];
			big       = big | (|absval[i][41:29]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= absval[i][28:0];
		end
		sat_s2  <= big;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
	end

	// stage 3: square each magnitude
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s3[i] <= mag_s2[i] * mag_s2[i];
		end
		sat_s3  <= sat_s2;
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
	end

	// sum, saturate, compare and count
	always_comb begin
		sum      = 60'(sq_s3[0]) + 60'(sq_s3[1]) + 60'(sq_s3[2]);
		dist_sat = (sat_s3 || (|sum[59:58])) ? DIST_MAX : sum[57:0];
		inl      = dist_sat < cfg.threshold_squared;
		total    = (inl && (count_q < COUNT_CAP)) ? count_q + 21'd1 : count_q;

		res_valid        = v_s3;
		res.is_inlier    = inl;
		res.inlier_index = idx_s3;
		res.dist_sq      = dist_sat;
		res.inlier_total = total;
		res.last_result  = last_s3;
	end

	// hold the running count; clear after the last point of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (v_s3) begin
			count_q <= last_s3 ? '0 : total;
		end
	end

endmodule
